>>> hw/rtl/bcrtc_pkg.sv
// Shared types and constants of the BCD real-time clock block.
// Used by bcrtc_calendar, bcrtc_core and the top level; depends on nothing.

package bcrtc_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_e;

	// time registers: index 0 seconds .. 6 years; alarms: 0 second .. 4 weekday
	typedef logic [6:0][7:0] time_regs_t;
	typedef logic [4:0][7:0] alarm_regs_t;

	typedef struct packed {
		logic [7:0]  ctrl1;
		logic [7:0]  ctrl2;
		logic [7:0]  offset;
		logic [7:0]  ram;
		time_regs_t  tm;
		alarm_regs_t al;
		logic [7:0]  tcount;
		logic [7:0]  treload;
		logic [7:0]  tmode;
		logic [5:0]  prescale;
	} rtc_state_t;

	typedef struct packed {
		cmd_e       command;
		logic [4:0] reg_addr;
		logic [7:0] write_data;
	} rtc_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
		logic       bad_address;
	} rtc_result_t;

	localparam rtc_state_t STATE_RST = '{
		ctrl1:    8'h00,
		ctrl2:    8'h00,
		offset:   8'h00,
		ram:      8'h00,
		tm:       {8'h00, 8'h01, 8'h06, 8'h01, 8'h00, 8'h00, 8'h80},
		al:       {8'h80, 8'h80, 8'h80, 8'h80, 8'h80},
		tcount:   8'h00,
		treload:  8'h00,
		tmode:    8'h18,
		prescale: 6'd0
	};

endpackage

>>> hw/rtl/bcd_rtc_calendar_alarm_timer.sv
// Path: an accepted item waits in the input register, then its result is held in
// the result register and offered from there; out_ready low holds both stages.
// Throughput: one item per cycle while out_ready is not held low;
// the register-file update and the tick logic are one combinational pass.
// Reset: arst_n asynchronously restores power-on register values; a write of
// 0x58 to control 1 restores them as well. Depends on bcrtc_pkg, bcrtc_core.

module bcd_rtc_calendar_alarm_timer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [4:0] reg_addr,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       irq,
	output logic       bad_address
);

	bcrtc_pkg::rtc_item_t   item_s1;
	logic                   valid_s1;
	bcrtc_pkg::rtc_result_t res_d;
	bcrtc_pkg::rtc_result_t res_q;
	logic                   out_valid_q;
	logic                   adv;
	logic                   step;

	assign adv      = !out_valid_q || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.command    <= bcrtc_pkg::cmd_e'(command);
			item_s1.reg_addr   <= reg_addr;
			item_s1.write_data <= write_data;
		end
	end

	bcrtc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = res_q.read_data;
	assign irq         = res_q.irq;
	assign bad_address = res_q.bad_address;

`ifndef ASSERT_OFF
	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("processed item did not reach the result register");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("stalled input stage lost or changed its item");

	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.bad_address |-> res_q.read_data == 8'h00)
		else $error("bad address result carries read data");
`endif

endmodule

>>> hw/rtl/bcrtc_calendar.sv
// One-second advance of the BCD time and date registers (24-hour, leap year
// every fourth year). Pure combinational; depends on bcrtc_pkg.

module bcrtc_calendar (
	input  bcrtc_pkg::time_regs_t tm_in,
	output bcrtc_pkg::time_regs_t tm_out
);

	typedef struct packed {
		logic [7:0] value;
		logic       carry;
	} bump_t;

	// Increment one BCD field under its mask, wrapping at last to first.
	// first is 0 or 1, so its BCD and binary forms agree.
	function automatic bump_t bcd_bump(input logic [7:0] r, input logic [7:0] m,
			input logic [6:0] first, input logic [6:0] last);
		logic [7:0] f;
		logic [3:0] hi;
		logic [3:0] lo;
		logic [7:0] bin;
		logic [7:0] inc;
		bump_t      b;
		f   = r & m;
		hi  = f[7:4];
		lo  = f[3:0];
		bin = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'h0, lo};
		b.carry = 1'b0;
		if (bin >= {1'b0, last}) begin
			b.carry = 1'b1;
			inc = {1'b0, first};
		end else if (lo >= 4'd9) begin
			// units digit of nine or above carries into the tens digit
			inc = {hi + 4'd1, lo - 4'd9};
		end else begin
			inc = {hi, lo + 4'd1};
		end
		b.value = (r & ~m) | (inc & m);
		return b;
	endfunction

	logic [4:0] month;
	logic       leap;
	logic [6:0] mdays;
	logic [2:0] wday;
	bump_t      sec_b, min_b, hour_b, day_b, mon_b, year_b;

	// month in binary; year mod 4 from (2*tens + units) mod 4
	assign month = tm_in[5][4] ? (5'd10 + {1'b0, tm_in[5][3:0]}) : {1'b0, tm_in[5][3:0]};
	assign leap  = (2'({tm_in[6][4], 1'b0}) + tm_in[6][1:0]) == 2'd0;

	always_comb begin
		case (month) inside
			5'd2:                      mdays = leap ? 7'd29 : 7'd28;
			5'd4, 5'd6, 5'd9, 5'd11:   mdays = 7'd30;
			default:                   mdays = 7'd31;
		endcase
	end

	assign sec_b  = bcd_bump(tm_in[0], 8'h7F, 7'd0, 7'd59);
	assign min_b  = bcd_bump(tm_in[1], 8'h7F, 7'd0, 7'd59);
	assign hour_b = bcd_bump(tm_in[2], 8'h3F, 7'd0, 7'd23);
	assign day_b  = bcd_bump(tm_in[3], 8'h3F, 7'd1, mdays);
	assign mon_b  = bcd_bump(tm_in[5], 8'h1F, 7'd1, 7'd12);
	assign year_b = bcd_bump(tm_in[6], 8'hFF, 7'd0, 7'd99);
	assign wday   = (tm_in[4][2:0] >= 3'd6) ? 3'd0 : tm_in[4][2:0] + 3'd1;

	always_comb begin
		tm_out    = tm_in;
		tm_out[0] = sec_b.value;
		if (sec_b.carry) begin
			tm_out[1] = min_b.value;
			if (min_b.carry) begin
				tm_out[2] = hour_b.value;
				if (hour_b.carry) begin
					tm_out[4] = {5'd0, wday};
					tm_out[3] = day_b.value;
					if (day_b.carry) begin
						tm_out[5] = mon_b.value;
						if (mon_b.carry) begin
							tm_out[6] = year_b.value;
						end
					end
				end
			end
		end
	end

endmodule

>>> hw/rtl/bcrtc_core.sv
// Register file and command execution: reads, masked writes, soft reset,
// and the tick path (calendar, alarm match, countdown timer).
// Depends on bcrtc_pkg and bcrtc_calendar.

module bcrtc_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  bcrtc_pkg::rtc_item_t   item,
	output bcrtc_pkg::rtc_result_t res
);

	localparam logic [4:0] ADDR_CTRL1  = 5'h00;
	localparam logic [4:0] ADDR_CTRL2  = 5'h01;
	localparam logic [4:0] ADDR_OFFSET = 5'h02;
	localparam logic [4:0] ADDR_RAM    = 5'h03;
	localparam logic [4:0] ADDR_SEC    = 5'h04;
	localparam logic [4:0] ADDR_YEAR   = 5'h0A;
	localparam logic [4:0] ADDR_ASEC   = 5'h0B;
	localparam logic [4:0] ADDR_AWDAY  = 5'h0F;
	localparam logic [4:0] ADDR_TVAL   = 5'h10;
	localparam logic [4:0] ADDR_TMODE  = 5'h11;

	localparam logic [7:0] SOFT_RESET  = 8'h58;
	localparam logic [1:0] TSRC_1HZ    = 2'd2;
	localparam logic [1:0] TSRC_MIN    = 2'd3;
	localparam logic [5:0] PRESCALE_END = 6'd59;

	localparam logic [6:0][7:0] TIME_WMASK =
		{8'hFF, 8'h1F, 8'h07, 8'h3F, 8'h3F, 8'h7F, 8'hFF};
	localparam logic [4:0][7:0] ALARM_WMASK = {8'h87, 8'hBF, 8'hBF, 8'hFF, 8'hFF};
	localparam logic [4:0][7:0] MATCH_MASK  = {8'h07, 8'h3F, 8'h3F, 8'h7F, 8'h7F};

	bcrtc_pkg::rtc_state_t state_q;
	bcrtc_pkg::rtc_state_t state_d;
	bcrtc_pkg::rtc_state_t tick_st;
	bcrtc_pkg::time_regs_t tm_adv;
	logic [2:0]            tidx;
	logic [2:0]            aidx;
	logic [7:0]            rd;
	logic                  bad;

	bcrtc_calendar u_calendar (
		.tm_in  (state_q.tm),
		.tm_out (tm_adv)
	);

	assign tidx = 3'(item.reg_addr - ADDR_SEC);
	assign aidx = 3'(item.reg_addr - ADDR_ASEC);

	// tick: advance time, then alarm check on the new time, then timer
	always_comb begin
		logic any_en;
		logic all_hit;
		logic fire;
		tick_st    = state_q;
		tick_st.tm = tm_adv;
		any_en     = 1'b0;
		all_hit    = 1'b1;
		fire       = 1'b0;
		for (int i = 0; i < 5; i++) begin
			if (!state_q.al[i][7]) begin
				any_en = 1'b1;
				if (((state_q.al[i] ^ tm_adv[i]) & MATCH_MASK[i]) != 8'h00) begin
					all_hit = 1'b0;
				end
			end
		end
		if (any_en && all_hit) begin
			tick_st.ctrl2[6] = 1'b1;
		end
		if (state_q.tmode[2] && state_q.tcount != 8'h00) begin
			if (state_q.tmode[4:3] == TSRC_1HZ) begin
				fire = 1'b1;
			end else if (state_q.tmode[4:3] == TSRC_MIN) begin
				if (state_q.prescale >= PRESCALE_END) begin
					tick_st.prescale = 6'd0;
					fire = 1'b1;
				end else begin
					tick_st.prescale = state_q.prescale + 6'd1;
				end
			end
		end
		if (fire) begin
			if (state_q.tcount <= 8'h01) begin
				tick_st.tcount   = state_q.treload;
				tick_st.ctrl2[3] = 1'b1;
			end else begin
				tick_st.tcount = state_q.tcount - 8'h01;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		rd      = 8'h00;
		bad     = 1'b0;
		unique case (item.command)
			bcrtc_pkg::CMD_READ: begin
				if (item.reg_addr > ADDR_TMODE) begin
					bad = 1'b1;
				end else begin
					unique case (item.reg_addr) inside
						ADDR_CTRL1:             rd = state_q.ctrl1;
						ADDR_CTRL2:             rd = state_q.ctrl2;
						ADDR_OFFSET:            rd = state_q.offset;
						ADDR_RAM:               rd = state_q.ram;
						[ADDR_SEC:ADDR_YEAR]:   rd = state_q.tm[tidx];
						[ADDR_ASEC:ADDR_AWDAY]: rd = state_q.al[aidx];
						ADDR_TVAL:              rd = state_q.tcount;
						default:                rd = state_q.tmode;
					endcase
				end
			end
			bcrtc_pkg::CMD_WRITE: begin
				if (item.reg_addr > ADDR_TMODE) begin
					bad = 1'b1;
				end else begin
					unique case (item.reg_addr) inside
						ADDR_CTRL1: begin
							if (item.write_data == SOFT_RESET) begin
								state_d = bcrtc_pkg::STATE_RST;
							end else begin
								state_d.ctrl1 = item.write_data;
							end
						end
						ADDR_CTRL2: begin
							// flags AF/TF only clear on zero, never set by a write
							state_d.ctrl2 = (item.write_data & 8'hB7)
								| (state_q.ctrl2 & item.write_data & 8'h48);
						end
						ADDR_OFFSET: state_d.offset = item.write_data;
						ADDR_RAM:    state_d.ram    = item.write_data;
						[ADDR_SEC:ADDR_YEAR]: begin
							state_d.tm[tidx] = item.write_data & TIME_WMASK[tidx];
						end
						[ADDR_ASEC:ADDR_AWDAY]: begin
							state_d.al[aidx] = item.write_data & ALARM_WMASK[aidx];
						end
						ADDR_TVAL: begin
							state_d.tcount   = item.write_data;
							state_d.treload  = item.write_data;
							state_d.prescale = 6'd0;
						end
						default: begin
							state_d.tmode    = item.write_data & 8'h1F;
							state_d.prescale = 6'd0;
						end
					endcase
				end
			end
			bcrtc_pkg::CMD_TICK: begin
				if (!state_q.ctrl1[5]) begin
					state_d = tick_st;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcrtc_pkg::STATE_RST;
		end else if (step) begin
			state_q <= state_d;
		end
	end

	assign res.read_data   = rd;
	assign res.bad_address = bad;
	assign res.irq         = (state_d.ctrl2[7] && state_d.ctrl2[6])
		|| (state_d.tmode[1] && state_d.ctrl2[3]);

endmodule

>>> sim/tb_bcd_rtc_calendar_alarm_timer.sv
// Self-checking testbench for bcd_rtc_calendar_alarm_timer: register reads, writes and ticks
// are driven through a burst/gap sender, results are checked against an in-bench RTC model.
// Depends on bcrtc_pkg and the bcd_rtc_calendar_alarm_timer RTL.

module tb_bcd_rtc_calendar_alarm_timer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 900;
	localparam int IDLE_LIMIT = 1000;

	localparam logic [4:0] ADDR_CTRL1     = 5'h00;
	localparam logic [4:0] ADDR_CTRL2     = 5'h01;
	localparam logic [4:0] ADDR_OFFSET    = 5'h02;
	localparam logic [4:0] ADDR_RAM       = 5'h03;
	localparam logic [4:0] ADDR_SECONDS   = 5'h04;
	localparam logic [4:0] ADDR_MINUTES   = 5'h05;
	localparam logic [4:0] ADDR_HOURS     = 5'h06;
	localparam logic [4:0] ADDR_DAYS      = 5'h07;
	localparam logic [4:0] ADDR_WEEKDAYS  = 5'h08;
	localparam logic [4:0] ADDR_MONTHS    = 5'h09;
	localparam logic [4:0] ADDR_YEARS     = 5'h0A;
	localparam logic [4:0] ADDR_ALARM_SEC = 5'h0B;
	localparam logic [4:0] ADDR_TIMER     = 5'h10;
	localparam logic [4:0] ADDR_TMODE     = 5'h11;
	localparam logic [4:0] ADDR_BAD_LO    = 5'h12;
	localparam logic [4:0] ADDR_BAD_HI    = 5'h1F;

	localparam int T_SEC  = 0;
	localparam int T_MIN  = 1;
	localparam int T_HOUR = 2;
	localparam int T_DAY  = 3;
	localparam int T_WDAY = 4;
	localparam int T_MON  = 5;
	localparam int T_YEAR = 6;

	localparam logic [7:0] CTL1_STOP  = 8'h20;
	localparam logic [7:0] SOFT_RESET = 8'h58;
	localparam logic [7:0] CTL2_AIE   = 8'h80;
	localparam logic [7:0] CTL2_AF    = 8'h40;
	localparam logic [7:0] CTL2_TF    = 8'h08;
	localparam logic [7:0] TMODE_TE   = 8'h04;
	localparam logic [7:0] TMODE_TIE  = 8'h02;
	localparam logic [7:0] TMODE_MASK = 8'h1F;
	localparam logic [1:0] SRC_SECOND = 2'd2;
	localparam logic [1:0] SRC_MINUTE = 2'd3;

	// index 0 = seconds / alarm second
	localparam logic [6:0][7:0] TIME_WMASK  = {8'hFF, 8'h1F, 8'h07, 8'h3F, 8'h3F, 8'h7F, 8'hFF};
	localparam logic [4:0][7:0] ALARM_WMASK = {8'h87, 8'hBF, 8'hBF, 8'hFF, 8'hFF};
	localparam logic [4:0][7:0] ALARM_MATCH = {8'h07, 8'h3F, 8'h3F, 8'h7F, 8'h7F};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] command = bcrtc_pkg::CMD_READ;
	logic [4:0] reg_addr = '0;
	logic [7:0] write_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] read_data;
	logic       irq;
	logic       bad_address;

	bcd_rtc_calendar_alarm_timer dut (.*);

	always #5 clk = ~clk;

	// RTC register image kept by the bench
	logic [7:0] rtc_ctl1, rtc_ctl2, rtc_offset, rtc_ram;
	logic [7:0] rtc_time [7];
	logic [7:0] rtc_alarm [5];
	logic [7:0] rtc_tcount, rtc_treload, rtc_tmode;
	logic [5:0] rtc_prescale;

	bcrtc_pkg::rtc_item_t   item_q [$];
	bcrtc_pkg::rtc_result_t result_q [$];

	int n_pushed, n_pred, n_got, n_err;
	int n_ticks, n_stopped, n_bad, n_alarm, n_expire, n_irq;

	function automatic void rtc_power_on();
		rtc_ctl1 = 8'h00;
		rtc_ctl2 = 8'h00;
		rtc_offset = 8'h00;
		rtc_ram = 8'h00;
		rtc_time = '{8'h80, 8'h00, 8'h00, 8'h01, 8'h06, 8'h01, 8'h00};
		for (int i = 0; i < 5; i++)
			rtc_alarm[i] = 8'h80;
		rtc_tcount = 8'h00;
		rtc_treload = 8'h00;
		rtc_tmode = 8'h18;
		rtc_prescale = 6'd0;
	endfunction

	function automatic int unsigned bcd_value(logic [7:0] v);
		return v[7:4] * 10 + v[3:0];
	endfunction

	// step one calendar field inside its mask; returns 1 on wrap
	function automatic bit bcd_advance(int idx, logic [7:0] mask, int unsigned lo,
			int unsigned hi);
		int unsigned v;
		logic [7:0]  enc;
		bit          wrap;
		v = bcd_value(rtc_time[idx] & mask);
		wrap = (v >= hi);
		v = wrap ? lo : v + 1;
		enc = {4'(v / 10), 4'(v % 10)};
		rtc_time[idx] = (rtc_time[idx] & ~mask) | (enc & mask);
		return wrap;
	endfunction

	function automatic bcrtc_pkg::rtc_result_t rtc_predict(bcrtc_pkg::rtc_item_t it);
		bcrtc_pkg::rtc_result_t res;
		logic [7:0]  keep;
		logic [2:0]  wday;
		int unsigned mon, yr, mdays;
		bit          any_on, all_hit, fire;
		res = '0;
		if (it.command == bcrtc_pkg::CMD_READ || it.command == bcrtc_pkg::CMD_WRITE) begin
			if (it.reg_addr > ADDR_TMODE) begin
				res.bad_address = 1'b1;
				n_bad++;
			end else if (it.command == bcrtc_pkg::CMD_READ) begin
				case (it.reg_addr)
					ADDR_CTRL1:  res.read_data = rtc_ctl1;
					ADDR_CTRL2:  res.read_data = rtc_ctl2;
					ADDR_OFFSET: res.read_data = rtc_offset;
					ADDR_RAM:    res.read_data = rtc_ram;
					ADDR_TIMER:  res.read_data = rtc_tcount;
					ADDR_TMODE:  res.read_data = rtc_tmode;
					default: begin
						if (it.reg_addr <= ADDR_YEARS)
							res.read_data = rtc_time[it.reg_addr - ADDR_SECONDS];
						else
							res.read_data = rtc_alarm[it.reg_addr - ADDR_ALARM_SEC];
					end
				endcase
			end else begin
				case (it.reg_addr)
					ADDR_CTRL1: begin
						if (it.write_data == SOFT_RESET)
							rtc_power_on();
						else
							rtc_ctl1 = it.write_data;
					end
					ADDR_CTRL2: begin
						// flags only survive a write of one, never get set by it
						keep = rtc_ctl2 & it.write_data & (CTL2_AF | CTL2_TF);
						rtc_ctl2 = (it.write_data & ~(CTL2_AF | CTL2_TF)) | keep;
					end
					ADDR_OFFSET: rtc_offset = it.write_data;
					ADDR_RAM:    rtc_ram = it.write_data;
					ADDR_TIMER: begin
						rtc_tcount = it.write_data;
						rtc_treload = it.write_data;
						rtc_prescale = 6'd0;
					end
					ADDR_TMODE: begin
						rtc_tmode = it.write_data & TMODE_MASK;
						rtc_prescale = 6'd0;
					end
					default: begin
						if (it.reg_addr <= ADDR_YEARS)
							rtc_time[it.reg_addr - ADDR_SECONDS] = it.write_data &
								TIME_WMASK[it.reg_addr - ADDR_SECONDS];
						else
							rtc_alarm[it.reg_addr - ADDR_ALARM_SEC] = it.write_data &
								ALARM_WMASK[it.reg_addr - ADDR_ALARM_SEC];
					end
				endcase
			end
		end else if (it.command == bcrtc_pkg::CMD_TICK) begin
			n_ticks++;
			if ((rtc_ctl1 & CTL1_STOP) != 8'h00) begin
				n_stopped++;
			end else begin
				if (bcd_advance(T_SEC, 8'h7F, 0, 59)) begin
					if (bcd_advance(T_MIN, 8'h7F, 0, 59)) begin
						if (bcd_advance(T_HOUR, 8'h3F, 0, 23)) begin
							wday = rtc_time[T_WDAY][2:0];
							rtc_time[T_WDAY] = (wday >= 3'd6) ? 8'h00 : {5'b0, wday + 3'd1};
							mon = bcd_value(rtc_time[T_MON] & 8'h1F);
							yr = bcd_value(rtc_time[T_YEAR]);
							if (mon < 1 || mon > 12)
								mdays = 31;
							else if (mon == 2)
								mdays = (yr % 4 == 0) ? 29 : 28;
							else if (mon == 4 || mon == 6 || mon == 9 || mon == 11)
								mdays = 30;
							else
								mdays = 31;
							if (bcd_advance(T_DAY, 8'h3F, 1, mdays)) begin
								if (bcd_advance(T_MON, 8'h1F, 1, 12))
									void'(bcd_advance(T_YEAR, 8'hFF, 0, 99));
							end
						end
					end
				end
				any_on = 1'b0;
				all_hit = 1'b1;
				for (int i = 0; i < 5; i++) begin
					if (!rtc_alarm[i][7]) begin
						any_on = 1'b1;
						if (((rtc_alarm[i] ^ rtc_time[i]) & ALARM_MATCH[i]) != 8'h00)
							all_hit = 1'b0;
					end
				end
				if (any_on && all_hit) begin
					rtc_ctl2 = rtc_ctl2 | CTL2_AF;
					n_alarm++;
				end
				fire = 1'b0;
				if ((rtc_tmode & TMODE_TE) != 8'h00 && rtc_tcount != 8'h00) begin
					if (rtc_tmode[4:3] == SRC_SECOND) begin
						fire = 1'b1;
					end else if (rtc_tmode[4:3] == SRC_MINUTE) begin
						if (rtc_prescale >= 6'd59) begin
							rtc_prescale = 6'd0;
							fire = 1'b1;
						end else begin
							rtc_prescale = rtc_prescale + 6'd1;
						end
					end
					if (fire) begin
						if (rtc_tcount <= 8'd1) begin
							rtc_tcount = rtc_treload;
							rtc_ctl2 = rtc_ctl2 | CTL2_TF;
							n_expire++;
						end else begin
							rtc_tcount = rtc_tcount - 8'd1;
						end
					end
				end
			end
		end
		res.irq = ((rtc_ctl2 & CTL2_AIE) != 8'h00 && (rtc_ctl2 & CTL2_AF) != 8'h00) ||
			((rtc_tmode & TMODE_TIE) != 8'h00 && (rtc_ctl2 & CTL2_TF) != 8'h00);
		if (res.irq)
			n_irq++;
		return res;
	endfunction

	// ---------------- sender ----------------
	logic                 took = 1'b0;
	bcrtc_pkg::rtc_item_t took_item;
	bcrtc_pkg::rtc_item_t drv_next;
	int                   burst_left, gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= bcrtc_pkg::CMD_READ;
			reg_addr <= '0;
			write_data <= '0;
			took <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			took <= in_valid && in_ready;
			took_item <= '{command: bcrtc_pkg::cmd_e'(command), reg_addr: reg_addr,
				write_data: write_data};
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					in_valid <= 1'b0;
				end else if (item_q.size() > 0) begin
					drv_next = item_q.pop_front();
					in_valid <= 1'b1;
					command <= drv_next.command;
					reg_addr <= drv_next.reg_addr;
					write_data <= drv_next.write_data;
					if (burst_left > 0) begin
						burst_left = burst_left - 1;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// prediction runs on the falling edge, away from the result checks
	always @(negedge clk) begin
		if (took) begin
			result_q.push_back(rtc_predict(took_item));
			n_pred++;
		end
	end

	// ---------------- receiver ----------------
	logic [7:0] stall_pat = 8'hFF;
	logic [4:0] stall_pos = '0;

	task automatic report_bad(string what, bcrtc_pkg::rtc_result_t want,
			bcrtc_pkg::rtc_result_t got);
		n_err++;
		if (n_err <= 10)
			$display("%t %s: expected rd=%02h irq=%0b bad=%0b, got rd=%02h irq=%0b bad=%0b",
				$realtime, what, want.read_data, want.irq, want.bad_address,
				got.read_data, got.irq, got.bad_address);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bcrtc_pkg::rtc_result_t got, want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{read_data: read_data, irq: irq, bad_address: bad_address};
				n_got++;
				if (result_q.size() == 0) begin
					report_bad("unexpected result", '0, got);
				end else begin
					want = result_q.pop_front();
					if (got.read_data !== want.read_data || got.irq !== want.irq ||
							got.bad_address !== want.bad_address)
						report_bad("result mismatch", want, got);
				end
			end
			stall_pos = stall_pos + 5'd1;
			if (stall_pos == 5'd0) begin
				if ($urandom_range(0, 3) == 0)
					stall_pat = 8'hFF;
				else
					stall_pat = 8'($urandom) | 8'h01;
			end
			out_ready <= stall_pat[stall_pos[2:0]];
		end
	end

	// ---------------- watchdog ----------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
			$display("FAIL bcd_rtc_calendar_alarm_timer");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	task automatic push_item(bcrtc_pkg::cmd_e c, logic [4:0] a, logic [7:0] d);
		item_q.push_back('{command: c, reg_addr: a, write_data: d});
		n_pushed++;
	endtask

	task automatic wait_drained();
		while (item_q.size() != 0 || n_pred != n_pushed || result_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] near_or_any(logic [7:0] lim);
		return ($urandom_range(0, 3) == 0) ? 8'($urandom) : lim;
	endfunction

	initial begin
		bit         paused;
		logic [4:0] a;
		logic [7:0] d;
		rtc_power_on();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// leap-day rollover from 23:59:59 on 28 Feb
		push_item(bcrtc_pkg::CMD_READ, ADDR_SECONDS, 8'h00);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_SECONDS, 8'h59);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_MINUTES, 8'h59);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_HOURS, 8'h23);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_DAYS, 8'h28);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_WEEKDAYS, 8'h06);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_MONTHS, 8'h02);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_YEARS, 8'h96);
		push_item(bcrtc_pkg::CMD_TICK, 5'h00, 8'h00);
		push_item(bcrtc_pkg::CMD_READ, ADDR_DAYS, 8'h00);
		// second alarm with interrupt, then clear the flag
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_ALARM_SEC, 8'h01);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_CTRL2, CTL2_AIE);
		push_item(bcrtc_pkg::CMD_TICK, 5'h00, 8'h00);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_CTRL2, CTL2_AIE);
		// timer of one at 1 Hz expires and reloads
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_TIMER, 8'h01);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_TMODE,
			{3'b000, SRC_SECOND, 3'b000} | TMODE_TE | TMODE_TIE);
		push_item(bcrtc_pkg::CMD_TICK, 5'h00, 8'h00);
		// stopped clock ignores ticks
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_CTRL1, CTL1_STOP);
		push_item(bcrtc_pkg::CMD_TICK, 5'h1F, 8'hFF);
		push_item(bcrtc_pkg::CMD_READ, ADDR_SECONDS, 8'h00);
		push_item(bcrtc_pkg::CMD_READ, ADDR_BAD_HI, 8'h00);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_BAD_LO, 8'hFF);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_CTRL1, SOFT_RESET);
		// all-ones contents: invalid BCD and an out-of-range month carry everything
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_SECONDS, 8'hFF);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_MINUTES, 8'hFF);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_HOURS, 8'hFF);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_DAYS, 8'hFF);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_MONTHS, 8'hFF);
		push_item(bcrtc_pkg::CMD_WRITE, ADDR_YEARS, 8'hFF);
		push_item(bcrtc_pkg::CMD_TICK, 5'h00, 8'h00);
		wait_drained();

		paused = 1'b0;
		while (n_pushed < N_RANDOM + 30) begin
			if (!paused && n_pushed >= N_RANDOM / 2 + 30) begin
				paused = 1'b1;
				wait_drained();
			end
			case ($urandom_range(0, 9))
				0, 1: begin
					if ($urandom_range(0, 3) != 0)
						push_item(bcrtc_pkg::CMD_WRITE, ADDR_CTRL1, 8'h00);
					repeat ($urandom_range(1, 70))
						push_item(bcrtc_pkg::CMD_TICK, 5'($urandom), 8'($urandom));
				end
				2, 3: begin
					push_item(bcrtc_pkg::CMD_WRITE, ADDR_SECONDS, near_or_any(8'h59));
					if ($urandom_range(0, 1))
						push_item(bcrtc_pkg::CMD_WRITE, ADDR_MINUTES, near_or_any(8'h59));
					if ($urandom_range(0, 1))
						push_item(bcrtc_pkg::CMD_WRITE, ADDR_HOURS, near_or_any(8'h23));
					if ($urandom_range(0, 1))
						push_item(bcrtc_pkg::CMD_WRITE, ADDR_DAYS,
							near_or_any($urandom_range(0, 1) ?
							8'h28 + 8'($urandom_range(0, 1)) : 8'h30 + 8'($urandom_range(0, 1))));
					if ($urandom_range(0, 1))
						push_item(bcrtc_pkg::CMD_WRITE, ADDR_WEEKDAYS, near_or_any(8'h06));
					if ($urandom_range(0, 1))
						push_item(bcrtc_pkg::CMD_WRITE, ADDR_MONTHS,
							near_or_any($urandom_range(0, 1) ? 8'h02 : 8'h12));
					if ($urandom_range(0, 1))
						push_item(bcrtc_pkg::CMD_WRITE, ADDR_YEARS,
							near_or_any($urandom_range(0, 1) ? 8'h99 : 8'h04));
					repeat ($urandom_range(1, 4))
						push_item(bcrtc_pkg::CMD_TICK, 5'($urandom), 8'($urandom));
					push_item(bcrtc_pkg::CMD_READ,
						5'($urandom_range(ADDR_SECONDS, ADDR_YEARS)), 8'($urandom));
				end
				4: begin
					for (int i = 0; i < 5; i++) begin
						if ($urandom_range(0, 1)) begin
							d = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
								{1'b0, 3'($urandom_range(0, 2)), 4'($urandom_range(0, 9))};
							push_item(bcrtc_pkg::CMD_WRITE, ADDR_ALARM_SEC + 5'(i), d);
						end
					end
					push_item(bcrtc_pkg::CMD_WRITE, ADDR_CTRL2,
						8'($urandom) | ($urandom_range(0, 1) ? CTL2_AIE : 8'h00));
				end
				5: begin
					case ($urandom_range(0, 2))
						0: d = {3'b000, SRC_SECOND, 3'b000} | TMODE_TE | TMODE_TIE;
						1: d = {3'b000, SRC_MINUTE, 3'b000} | TMODE_TE | TMODE_TIE;
						default: d = 8'($urandom);
					endcase
					push_item(bcrtc_pkg::CMD_WRITE, ADDR_TMODE, d);
					push_item(bcrtc_pkg::CMD_WRITE, ADDR_TIMER,
						($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4)));
					repeat ($urandom_range(1, 8))
						push_item(bcrtc_pkg::CMD_TICK, 5'($urandom), 8'($urandom));
					push_item(bcrtc_pkg::CMD_READ, ADDR_TIMER, 8'($urandom));
				end
				6: begin
					case ($urandom_range(0, 5))
						3: d = CTL1_STOP;
						4: d = SOFT_RESET;
						5: d = 8'($urandom) & ~CTL1_STOP;
						default: d = 8'h00;
					endcase
					push_item(bcrtc_pkg::CMD_WRITE, ADDR_CTRL1, d);
					a = $urandom_range(0, 1) ? ADDR_RAM : ADDR_OFFSET;
					push_item(bcrtc_pkg::CMD_WRITE, a, 8'($urandom));
					push_item(bcrtc_pkg::CMD_READ, a, 8'($urandom));
				end
				default: begin
					repeat ($urandom_range(1, 8)) begin
						a = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(ADDR_BAD_LO, ADDR_BAD_HI)) :
							5'($urandom_range(ADDR_CTRL1, ADDR_TMODE));
						d = 8'($urandom);
						case ($urandom_range(0, 2))
							0: push_item(bcrtc_pkg::CMD_READ, a, d);
							1: begin
								// keep the clock running most of the time
								if (a == ADDR_CTRL1 && $urandom_range(0, 3) != 0)
									d = d & ~CTL1_STOP;
								push_item(bcrtc_pkg::CMD_WRITE, a, d);
							end
							default: push_item(bcrtc_pkg::CMD_TICK, a, d);
						endcase
					end
				end
			endcase
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Run covered %0d transfers: %0d ticks (%0d with the clock stopped), %0d bad addresses.",
			n_pred, n_ticks, n_stopped, n_bad);
		$display("Alarm matches %0d, timer expiries %0d, irq high on %0d results, %0d mismatches.",
			n_alarm, n_expire, n_irq, n_err);
		if (n_err == 0)
			$display("PASS bcd_rtc_calendar_alarm_timer");
		else
			$display("FAIL bcd_rtc_calendar_alarm_timer");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/bcrtc_pkg.sv
hw/rtl/bcrtc_calendar.sv
hw/rtl/bcrtc_core.sv
hw/rtl/bcd_rtc_calendar_alarm_timer.sv
sim/tb_bcd_rtc_calendar_alarm_timer.sv
